[rtl/chol_pkg.sv]
`timescale 1ns / 1ps
// shared constants for the 3x3 cholesky factor pipeline
// no dependencies; used by every module of the block
package chol_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // pipeline stall control shared by the arithmetic units
  typedef struct packed {
    logic en;
    logic vld;
  } chol_ctl_t;

endpackage

[rtl/chol_sqrt_pipe.sv]
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage, of pivot * 2^F
// saturates the root to the diagonal width and forces it to at least one; uses chol_pkg
module chol_sqrt_pipe #(
  parameter int DW = chol_pkg::DATA_WIDTH_DEF,
  parameter int F  = chol_pkg::FRAC_BITS_DEF,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  chol_pkg::chol_ctl_t ctl,
  input  logic [DW-2:0]       pivot,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [DW-2:0]       diag,
  output logic [SW-1:0]       out_side
);

  localparam int RW   = (DW + F) / 2;
  localparam int NW   = 2 * RW;
  localparam int REMW = RW + 2;
  localparam int CW   = (RW > DW - 1) ? RW : DW - 1;

  logic            v_q    [RW];
  logic [REMW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [NW-1:0]   nsh_q  [RW];
  logic [SW-1:0]   side_q [RW];

  logic [NW-1:0] n0;
  assign n0 = NW'({pivot, {F{1'b0}}});

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic            vi;
    logic [REMW-1:0] remi;
    logic [RW-1:0]   rooti;
    logic [NW-1:0]   nshi;
    logic [SW-1:0]   sidei;
    logic [REMW-1:0] rem_in;
    logic [REMW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vi    = ctl.vld;
      assign remi  = '0;
      assign rooti = '0;
      assign nshi  = n0;
      assign sidei = in_side;
    end else begin : g_next
      assign vi    = v_q[k-1];
      assign remi  = rem_q[k-1];
      assign rooti = root_q[k-1];
      assign nshi  = nsh_q[k-1];
      assign sidei = side_q[k-1];
    end

    // bring down two radicand bits, try (root << 2) | 1
    assign rem_in = {remi[REMW-3:0], nshi[NW-1 -: 2]};
    assign trial  = {rooti, 2'b01};
    assign ge     = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (ctl.en) begin
        v_q[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_q[k]  <= ge ? (rem_in - trial) : rem_in;
        root_q[k] <= {rooti[RW-2:0], ge};
        nsh_q[k]  <= {nshi[NW-3:0], 2'b00};
        side_q[k] <= sidei;
      end
    end
  end

  logic [CW-1:0] rx;
  logic [CW-1:0] smax;
  assign rx   = CW'(root_q[RW-1]);
  assign smax = CW'({(DW-1){1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      out_valid <= v_q[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      out_side <= side_q[RW-1];
      if (rx > smax) begin
        diag <= {(DW-1){1'b1}};
      end else if (rx == '0) begin
        diag <= (DW-1)'(1);
      end else begin
        diag <= rx[DW-2:0];
      end
    end
  end

endmodule

[rtl/chol_div_pipe.sv]
`timescale 1ns / 1ps
// pipelined signed fixed-point divide, one quotient bit per stage
// computes trunc(num * 2^F / d) saturated to DW signed bits per lane; uses chol_pkg
module chol_div_pipe #(
  parameter int DW   = chol_pkg::DATA_WIDTH_DEF,
  parameter int F    = chol_pkg::FRAC_BITS_DEF,
  parameter int NUMW = chol_pkg::DATA_WIDTH_DEF,
  parameter int LN   = 1,
  parameter int SW   = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  chol_pkg::chol_ctl_t       ctl,
  input  logic [LN-1:0][NUMW-1:0]   num,
  input  logic [DW-2:0]             d,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [LN-1:0][DW-1:0]     quo,
  output logic [SW-1:0]             out_side
);

  localparam int RW   = DW;
  localparam int SCW  = NUMW + F;
  localparam int HIW  = SCW - DW;
  localparam int CW   = (HIW > RW) ? HIW : RW;

  // stage a: sign and magnitude
  logic                    va;
  logic [LN-1:0]           nega;
  logic [LN-1:0][NUMW-1:0] maga;
  logic [DW-2:0]           da;
  logic [SW-1:0]           sidea;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ctl.en) begin
      va <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int l = 0; l < LN; l++) begin
        nega[l] <= num[l][NUMW-1];
        maga[l] <= num[l][NUMW-1] ? (~num[l] + NUMW'(1)) : num[l];
      end
      da    <= d;
      sidea <= in_side;
    end
  end

  // stage b: overflow test on the high part, initial remainder
  logic                    vb;
  logic [LN-1:0]           negb;
  logic [LN-1:0]           ovfb;
  logic [LN-1:0][RW-1:0]   remb;
  logic [LN-1:0][DW-1:0]   lowb;
  logic [DW-2:0]           db;
  logic [SW-1:0]           sideb;

  logic [LN-1:0][SCW-1:0]  scl;
  logic [LN-1:0][CW-1:0]   hix;
  logic [LN-1:0]           ovf_c;
  logic [CW-1:0]           dx;

  always_comb begin
    dx = CW'(da);
    for (int l = 0; l < LN; l++) begin
      scl[l]   = {maga[l], {F{1'b0}}};
      hix[l]   = CW'(scl[l][SCW-1:DW]);
      ovf_c[l] = (hix[l] >= dx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ctl.en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int l = 0; l < LN; l++) begin
        negb[l] <= nega[l];
        ovfb[l] <= ovf_c[l];
        remb[l] <= ovf_c[l] ? '0 : hix[l][RW-1:0];
        lowb[l] <= scl[l][DW-1:0];
      end
      db    <= da;
      sideb <= sidea;
    end
  end

  // quotient bit stages
  logic                  vs_q   [DW];
  logic [LN-1:0]         neg_s  [DW];
  logic [LN-1:0]         ovf_s  [DW];
  logic [LN-1:0][RW-1:0] rem_s  [DW];
  logic [LN-1:0][DW-1:0] low_s  [DW];
  logic [LN-1:0][DW-1:0] q_s    [DW];
  logic [DW-2:0]         d_s    [DW];
  logic [SW-1:0]         side_s [DW];

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic                  vi;
    logic [LN-1:0]         negi;
    logic [LN-1:0]         ovfi;
    logic [LN-1:0][RW-1:0] remi;
    logic [LN-1:0][DW-1:0] lowi;
    logic [LN-1:0][DW-1:0] qi;
    logic [DW-2:0]         di;
    logic [SW-1:0]         sidei;
    logic [LN-1:0][RW-1:0] rem_in;
    logic [LN-1:0][RW-1:0] rem_n;
    logic [LN-1:0]         ge;

    if (k == 0) begin : g_first
      assign vi    = vb;
      assign negi  = negb;
      assign ovfi  = ovfb;
      assign remi  = remb;
      assign lowi  = lowb;
      assign qi    = '0;
      assign di    = db;
      assign sidei = sideb;
    end else begin : g_next
      assign vi    = vs_q[k-1];
      assign negi  = neg_s[k-1];
      assign ovfi  = ovf_s[k-1];
      assign remi  = rem_s[k-1];
      assign lowi  = low_s[k-1];
      assign qi    = q_s[k-1];
      assign di    = d_s[k-1];
      assign sidei = side_s[k-1];
    end

    always_comb begin
      for (int l = 0; l < LN; l++) begin
        rem_in[l] = {remi[l][RW-2:0], lowi[l][DW-1]};
        ge[l]     = (rem_in[l] >= {1'b0, di});
        rem_n[l]  = ge[l] ? (rem_in[l] - {1'b0, di}) : rem_in[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs_q[k] <= 1'b0;
      end else if (ctl.en) begin
        vs_q[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        for (int l = 0; l < LN; l++) begin
          rem_s[k][l] <= rem_n[l];
          low_s[k][l] <= {lowi[l][DW-2:0], 1'b0};
          q_s[k][l]   <= {qi[l][DW-2:0], ge[l]};
        end
        neg_s[k]  <= negi;
        ovf_s[k]  <= ovfi;
        d_s[k]    <= di;
        side_s[k] <= sidei;
      end
    end
  end

  // restore sign and saturate
  logic [LN-1:0][DW-1:0] qf;
  logic [LN-1:0][DW-1:0] sat_c;

  always_comb begin
    qf = q_s[DW-1];
    for (int l = 0; l < LN; l++) begin
      if (neg_s[DW-1][l]) begin
        if (ovf_s[DW-1][l] || (qf[l][DW-1] && (qf[l][DW-2:0] != '0))) begin
          sat_c[l] = {1'b1, {(DW-1){1'b0}}};
        end else begin
          sat_c[l] = ~qf[l] + DW'(1);
        end
      end else begin
        if (ovf_s[DW-1][l] || qf[l][DW-1]) begin
          sat_c[l] = {1'b0, {(DW-1){1'b1}}};
        end else begin
          sat_c[l] = qf[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      out_valid <= vs_q[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      quo      <= sat_c;
      out_side <= side_s[DW-1];
    end
  end

endmodule

[rtl/cholesky_decompose_3x3_top.sv]
`timescale 1ns / 1ps
// 3x3 cholesky factor, deeply pipelined: one matrix per cycle, no state kept
// the path runs through three bit-per-stage square roots and two bit-per-stage divides
// in series, with registers for the input, products, pivots and output between them
// throughput one beat per cycle while m_tready stays high; a stall holds the whole pipe
// rst (synchronous) empties the pipe; no other state to clear
// depends on chol_pkg, chol_sqrt_pipe, chol_div_pipe
module cholesky_decompose_3x3_top #(
  parameter int DATA_WIDTH = chol_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = chol_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // a11, a21, a31, a22, a32, a33 from bit 0, DATA_WIDTH bits each
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // l11, l21, l31, l22, l32, l33 from bit 0; diagonals DATA_WIDTH-1 bits
  output logic [((6*DATA_WIDTH-3+7)/8)*8-1:0]     m_tdata,
  // status
  output logic                                    m_tuser
);

  localparam int DW     = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int PW     = 2 * DW - F + 2;
  localparam int OUT_TW = ((6 * DW - 3 + 7) / 8) * 8;
  localparam int SW1    = 1 + 5 * DW;
  localparam int SW2    = 1 + (DW - 1) + 3 * DW;
  localparam int SW3    = 1 + (DW - 1) + 2 * DW + 2 * PW;
  localparam int SW4    = 1 + 2 * (DW - 1) + 2 * DW + PW;
  localparam int SW5    = 1 + 2 * (DW - 1) + 3 * DW;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input register
  logic                 v0;
  logic                 e0;
  logic signed [DW-1:0] a11, a21, a31, a22, a32, a33;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a11 <= s_tdata[DW-1:0];
      a21 <= s_tdata[2*DW-1:DW];
      a31 <= s_tdata[3*DW-1:2*DW];
      a22 <= s_tdata[4*DW-1:3*DW];
      a32 <= s_tdata[5*DW-1:4*DW];
      a33 <= s_tdata[6*DW-1:5*DW];
      e0  <= s_tdata[DW-1] || (s_tdata[DW-1:0] == '0);
    end
  end

  // l11 = sqrt(a11)
  chol_pkg::chol_ctl_t ctl1, ctl2, ctl3, ctl4, ctl5;
  logic                v1;
  logic [DW-2:0]       l11_1;
  logic [SW1-1:0]      side1;

  assign ctl1 = '{en: en, vld: v0};

  chol_sqrt_pipe #(.DW(DW), .F(F), .SW(SW1)) u_sqrt1 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl1),
    .pivot    (a11[DW-2:0]),
    .in_side  ({e0, a21, a31, a22, a32, a33}),
    .out_valid(v1),
    .diag     (l11_1),
    .out_side (side1)
  );

  logic          e1;
  logic [DW-1:0] b21, b31, b22, b32, b33;
  assign {e1, b21, b31, b22, b32, b33} = side1;

  // l21, l31 = a21 / l11, a31 / l11
  logic                  v2;
  logic [1:0][DW-1:0]    q1;
  logic [SW2-1:0]        side2;

  assign ctl2 = '{en: en, vld: v1};

  chol_div_pipe #(.DW(DW), .F(F), .NUMW(DW), .LN(2), .SW(SW2)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl2),
    .num      ({b31, b21}),
    .d        (l11_1),
    .in_side  ({e1, l11_1, b22, b32, b33}),
    .out_valid(v2),
    .quo      (q1),
    .out_side (side2)
  );

  logic          e2;
  logic [DW-2:0] c11;
  logic [DW-1:0] c22, c32, c33;
  assign {e2, c11, c22, c32, c33} = side2;

  // products of the first column
  logic                   v3, e3;
  logic [DW-2:0]          m11;
  logic signed [DW-1:0]   m21, m31, m22, m32, m33;
  logic signed [2*DW-1:0] sq21, pr2131, sq31;
  logic signed [DW-1:0]   l21_s, l31_s;

  assign l21_s = q1[0];
  assign l31_s = q1[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e3     <= e2;
      m11    <= c11;
      m21    <= l21_s;
      m31    <= l31_s;
      m22    <= c22;
      m32    <= c32;
      m33    <= c33;
      sq21   <= l21_s * l21_s;
      pr2131 <= l21_s * l31_s;
      sq31   <= l31_s * l31_s;
    end
  end

  // second pivot and residuals, floor shift
  logic signed [PW-1:0] p2_c, res_c, t3_c;
  assign p2_c  = PW'(m22) - PW'(sq21 >>> F);
  assign res_c = PW'(m32) - PW'(pr2131 >>> F);
  assign t3_c  = PW'(m33) - PW'(sq31 >>> F);

  logic                 v4, e4;
  logic [DW-2:0]        n11;
  logic [DW-1:0]        n21, n31;
  logic signed [PW-1:0] p2, res, t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e4  <= e3 || p2_c[PW-1] || (p2_c == '0);
      n11 <= m11;
      n21 <= m21;
      n31 <= m31;
      p2  <= p2_c;
      res <= res_c;
      t3  <= t3_c;
    end
  end

  // l22 = sqrt(pivot2)
  logic           v5;
  logic [DW-2:0]  l22_2;
  logic [SW3-1:0] side3;

  assign ctl3 = '{en: en, vld: v4};

  chol_sqrt_pipe #(.DW(DW), .F(F), .SW(SW3)) u_sqrt2 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl3),
    .pivot    (p2[DW-2:0]),
    .in_side  ({e4, n11, n21, n31, res, t3}),
    .out_valid(v5),
    .diag     (l22_2),
    .out_side (side3)
  );

  logic          e5;
  logic [DW-2:0] o11;
  logic [DW-1:0] o21, o31;
  logic [PW-1:0] ores, ot3;
  assign {e5, o11, o21, o31, ores, ot3} = side3;

  // l32 = residual / l22
  logic                  v6;
  logic [0:0][DW-1:0]    q2;
  logic [SW4-1:0]        side4;

  assign ctl4 = '{en: en, vld: v5};

  chol_div_pipe #(.DW(DW), .F(F), .NUMW(PW), .LN(1), .SW(SW4)) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl4),
    .num      (ores),
    .d        (l22_2),
    .in_side  ({e5, o11, o21, o31, l22_2, ot3}),
    .out_valid(v6),
    .quo      (q2),
    .out_side (side4)
  );

  logic          e6;
  logic [DW-2:0] r11, r22;
  logic [DW-1:0] r21, r31;
  logic [PW-1:0] rt3;
  assign {e6, r11, r21, r31, r22, rt3} = side4;

  // square of l32
  logic                   v7, e7;
  logic [DW-2:0]          w11, w22;
  logic [DW-1:0]          w21, w31, w32;
  logic signed [PW-1:0]   wt3;
  logic signed [2*DW-1:0] sq32;
  logic signed [DW-1:0]   l32_s;

  assign l32_s = q2[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e7   <= e6;
      w11  <= r11;
      w21  <= r21;
      w31  <= r31;
      w22  <= r22;
      w32  <= l32_s;
      wt3  <= rt3;
      sq32 <= l32_s * l32_s;
    end
  end

  // third pivot
  logic signed [PW-1:0] p3_c;
  assign p3_c = wt3 - PW'(sq32 >>> F);

  logic                 v8, e8;
  logic [DW-2:0]        x11, x22;
  logic [DW-1:0]        x21, x31, x32;
  logic signed [PW-1:0] p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e8  <= e7 || p3_c[PW-1] || (p3_c == '0);
      x11 <= w11;
      x21 <= w21;
      x31 <= w31;
      x22 <= w22;
      x32 <= w32;
      p3  <= p3_c;
    end
  end

  // l33 = sqrt(pivot3)
  logic           v9;
  logic [DW-2:0]  l33_3;
  logic [SW5-1:0] side5;

  assign ctl5 = '{en: en, vld: v8};

  chol_sqrt_pipe #(.DW(DW), .F(F), .SW(SW5)) u_sqrt3 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl5),
    .pivot    (p3[DW-2:0]),
    .in_side  ({e8, x11, x21, x31, x22, x32}),
    .out_valid(v9),
    .diag     (l33_3),
    .out_side (side5)
  );

  logic          e9;
  logic [DW-2:0] y11, y22;
  logic [DW-1:0] y21, y31, y32;
  assign {e9, y11, y21, y31, y22, y32} = side5;

  // output register, a bad pivot anywhere zeroes the factor
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= e9;
      if (e9) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= OUT_TW'({l33_3, y32, y22, y31, y21, y11});
      end
    end
  end

  // a failed factor is all zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error beat carries nonzero factor");

  // a good factor has a positive first diagonal
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[DW-2:0] != '0)
    else $error("good beat with zero diagonal");

  // input side stalls only behind a held output beat
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // a held output beat does not change
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("held output beat changed");

endmodule
